@@ rtl/hrsp_pkg.sv @@
package hrsp_pkg;

  localparam int unsigned DEF_LENGTH_BITS = 32;
  localparam int unsigned NAME_LEN        = 14;
  localparam int unsigned POS_BITS        = 4;

  // section codes carried on out_tuser
  localparam logic [2:0] SEC_PROTOCOL = 3'd0;
  localparam logic [2:0] SEC_STATUS   = 3'd1;
  localparam logic [2:0] SEC_REASON   = 3'd2;
  localparam logic [2:0] SEC_NAME     = 3'd3;
  localparam logic [2:0] SEC_VALUE    = 3'd4;
  localparam logic [2:0] SEC_BODY     = 3'd5;
  localparam logic [2:0] SEC_DONE     = 3'd6;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // characters of the header name that carries the body length
  function automatic logic [7:0] cl_name_char(input logic [POS_BITS-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/http_response_stream_parser.sv @@
// HTTP response stream parser.
// Input channel (in_*): one response byte per word in in_tdata; in_tuser set
// starts a new response, the parser state is cleared before that byte.
// Result channel (out_*): one word per byte that yields a result; carriage
// returns in the header, the first byte of each header value and any byte
// after the response completed yield none. out_tuser gives the section,
// out_tlast marks the word that completes the response.
// A byte accepted goes into the input register, then its result word into
// the result register. Throughput: one byte per cycle while the receiver
// takes every word; the parse state, the name matcher and the length
// accumulator all update when the byte moves between those two registers.
// Content-Length digits go through one shift-add and compare per byte.
// Reset (rst_n low, synchronous): both stages empty, parser in the protocol
// field with length and body count zero.
// When the receiver stalls the result word holds, the input register holds
// its byte and in_tready drops; no word is lost or repeated.
module http_response_stream_parser #(
  parameter int unsigned LENGTH_BITS = hrsp_pkg::DEF_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] data_byte, [8] byte_valid, [9] field_end,
                                  // [10] headers_done, [42:11] length_value, zero fill
  output logic [2:0]  out_tuser,  // [2:0] section
  output logic        out_tlast   // complete
);
  import hrsp_pkg::*;

  typedef enum logic [2:0] {
    PH_PROTOCOL = 3'd0,
    PH_STATUS   = 3'd1,
    PH_REASON   = 3'd2,
    PH_NAME     = 3'd3,
    PH_VALUE    = 3'd4,
    PH_BODY     = 3'd5,
    PH_DONE     = 3'd6
  } phase_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_restart_r;

  // parser state
  phase_t                 phase_r, phase_nxt;
  logic [POS_BITS-1:0]    pos_r, pos_nxt;
  logic                   match_r, match_nxt;
  logic                   vfp_r, vfp_nxt;
  logic                   dend_r, dend_nxt;
  logic [LENGTH_BITS-1:0] clen_r, clen_nxt;
  logic [LENGTH_BITS-1:0] bcnt_r, bcnt_nxt;

  // result stage
  logic       out_valid_r;
  logic [2:0] sec_r;
  logic [7:0] dbyte_r;
  logic       bval_r, fend_r, hdone_r, done_r;
  logic [31:0] lenv_r;

  logic advance, s1_fire;
  assign advance   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  // state seen by this byte, after an optional restart
  phase_t                 cur_phase;
  logic [POS_BITS-1:0]    cur_pos;
  logic                   cur_match, cur_vfp, cur_dend;
  logic [LENGTH_BITS-1:0] cur_clen, cur_bcnt;

  logic                   res, valid, fend, hdone, done;
  logic [7:0]             b;
  logic [3:0]             digit;
  logic [LENGTH_BITS+3:0] acc;
  logic [LENGTH_BITS-1:0] bcnt_inc;
  logic                   is_cl;
  logic [LENGTH_BITS+31:0] len_ext;

  always_comb begin
    b         = s1_byte_r;
    cur_phase = s1_restart_r ? PH_PROTOCOL : phase_r;
    cur_pos   = s1_restart_r ? '0 : pos_r;
    cur_match = s1_restart_r ? 1'b1 : match_r;
    cur_vfp   = s1_restart_r ? 1'b0 : vfp_r;
    cur_dend  = s1_restart_r ? 1'b0 : dend_r;
    cur_clen  = s1_restart_r ? '0 : clen_r;
    cur_bcnt  = s1_restart_r ? '0 : bcnt_r;

    phase_nxt = cur_phase;
    pos_nxt   = cur_pos;
    match_nxt = cur_match;
    vfp_nxt   = cur_vfp;
    dend_nxt  = cur_dend;
    clen_nxt  = cur_clen;
    bcnt_nxt  = cur_bcnt;

    res   = 1'b1;
    valid = 1'b0;
    fend  = 1'b0;
    hdone = 1'b0;
    done  = 1'b0;

    is_cl = cur_match && (cur_pos == POS_BITS'(NAME_LEN));
    digit = 4'(b - CH_ZERO);
    // cl*10 + d, wide enough to see overflow
    acc = ({4'b0, cur_clen} << 3) + ({4'b0, cur_clen} << 1) + (LENGTH_BITS+4)'(digit);
    bcnt_inc = (cur_bcnt < LEN_MAX) ? cur_bcnt + 1'b1 : cur_bcnt;

    if (cur_phase == PH_DONE) begin
      res = 1'b0;
    end else if (cur_phase != PH_BODY && b == CH_CR) begin
      res = 1'b0;
    end else begin
      case (cur_phase)
        PH_PROTOCOL, PH_STATUS: begin
          if (b == CH_SPACE) begin
            fend      = 1'b1;
            phase_nxt = (cur_phase == PH_PROTOCOL) ? PH_STATUS : PH_REASON;
          end else begin
            valid = 1'b1;
          end
        end
        PH_REASON: begin
          if (b == CH_LF) begin
            fend      = 1'b1;
            phase_nxt = PH_NAME;
            pos_nxt   = '0;
            match_nxt = 1'b1;
          end else begin
            valid = 1'b1;
          end
        end
        PH_NAME: begin
          if (b == CH_LF) begin
            hdone = 1'b1;
            if (cur_clen != '0) begin
              phase_nxt = PH_BODY;
              bcnt_nxt  = '0;
            end else begin
              phase_nxt = PH_DONE;
              done      = 1'b1;
            end
          end else if (b == CH_COLON) begin
            fend      = 1'b1;
            phase_nxt = PH_VALUE;
            vfp_nxt   = 1'b1;
            dend_nxt  = 1'b0;
            if (is_cl) clen_nxt = '0;
          end else begin
            valid = 1'b1;
            if (cur_pos < POS_BITS'(NAME_LEN) && b == cl_name_char(cur_pos))
              pos_nxt = cur_pos + 1'b1;
            else
              match_nxt = 1'b0;
          end
        end
        PH_VALUE: begin
          if (b == CH_LF) begin
            fend      = 1'b1;
            vfp_nxt   = 1'b0;
            phase_nxt = PH_NAME;
            pos_nxt   = '0;
            match_nxt = 1'b1;
          end else if (cur_vfp) begin
            // separator after the colon is swallowed
            vfp_nxt = 1'b0;
            res     = 1'b0;
          end else begin
            valid = 1'b1;
            if (is_cl && !cur_dend) begin
              if (b >= CH_ZERO && b <= CH_NINE) begin
                if (acc > {4'b0, LEN_MAX}) clen_nxt = LEN_MAX;
                else clen_nxt = acc[LENGTH_BITS-1:0];
              end else begin
                dend_nxt = 1'b1;
              end
            end
          end
        end
        PH_BODY: begin
          valid    = 1'b1;
          bcnt_nxt = bcnt_inc;
          if (bcnt_inc >= cur_clen) begin
            phase_nxt = PH_DONE;
            fend      = 1'b1;
            done      = 1'b1;
          end
        end
        default: res = 1'b0;
      endcase
    end
    len_ext = {32'b0, clen_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_PROTOCOL;
      pos_r       <= '0;
      match_r     <= 1'b1;
      vfp_r       <= 1'b0;
      dend_r      <= 1'b0;
      clen_r      <= '0;
      bcnt_r      <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r && res;
      end
      if (s1_fire) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        match_r <= match_nxt;
        vfp_r   <= vfp_nxt;
        dend_r  <= dend_nxt;
        clen_r  <= clen_nxt;
        bcnt_r  <= bcnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r    <= in_tdata;
      s1_restart_r <= in_tuser;
    end
    if (s1_fire && res) begin
      sec_r   <= 3'(cur_phase);
      dbyte_r <= valid ? b : 8'h00;
      bval_r  <= valid;
      fend_r  <= fend;
      hdone_r <= hdone;
      done_r  <= done;
      lenv_r  <= len_ext[31:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, lenv_r, hdone_r, fend_r, bval_r, dbyte_r};
  assign out_tuser  = sec_r;
  assign out_tlast  = done_r;

  // end of header never carries a byte or closes a field
  a_hdone_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hdone_r |-> !bval_r && !fend_r)
    else $error("headers_done word carries a byte");

  // every body word carries its byte
  a_body_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sec_r == SEC_BODY |-> bval_r)
    else $error("body word without byte");

  // the body count stays below the length while in the body
  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> bcnt_r < clen_r)
    else $error("body count reached length without completion");

  // a finished parse stays finished until restart
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && phase_r == PH_DONE && !s1_restart_r |=> phase_r == PH_DONE && !out_valid_r)
    else $error("result or state change after completion");

endmodule
